// ----- design/circ_pkg.sv -----
// ============================================================================
// circ_pkg
// Shared widths, command codes and the step job type of the circle rasterizer.
// ============================================================================
package circ_pkg;

  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 12;
  localparam int OUT_W    = COORD_W + 1;
  localparam int DEC_W    = RADIUS_W + 3;
  localparam int EXT_W    = RADIUS_W + 4;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IDX_W = 3;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // One step as handed from the front end to the back end.
  typedef struct packed {
    logic                       live;   // 0: step while idle
    logic                       fill;
    logic                       done;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic        [RADIUS_W-1:0] ox;
    logic        [RADIUS_W-1:0] oy;
  } job_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
  } q_wr_stat_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic empty;
  } q_rd_stat_t;

endpackage

// ----- design/circ_if.sv -----
// ============================================================================
// circ_if
// Valid/ready channels for start and step requests and for rasterizer results.
// ============================================================================
interface circ_in_if;
  import circ_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [COORD_W-1:0]  center_x;
  logic signed [COORD_W-1:0]  center_y;
  logic        [RADIUS_W-1:0] radius;
  logic                       filled;

  modport source (output valid, command, center_x, center_y, radius, filled,
                  input ready);
  modport sink   (input valid, command, center_x, center_y, radius, filled,
                  output ready);
endinterface

interface circ_out_if;
  import circ_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_start;
  logic signed [OUT_W-1:0] x_end;
  logic signed [OUT_W-1:0] y_coord;
  logic                    valid_res;
  logic                    last;
  logic                    done_res;

  modport source (output valid, x_start, x_end, y_coord, valid_res, last, done_res,
                  input ready);
  modport sink   (input valid, x_start, x_end, y_coord, valid_res, last, done_res,
                  output ready);
endinterface

// ----- design/circ_fifo.sv -----
// ============================================================================
// circ_fifo
// Short register queue of step jobs between the front and back ends.
// ============================================================================
module circ_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  circ_pkg::job_t      push_job,
  output circ_pkg::q_wr_stat_t wr_stat,
  input  logic                pop,
  output circ_pkg::job_t      head_job,
  output circ_pkg::q_rd_stat_t rd_stat
);
  import circ_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign wr_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign rd_stat.empty = (cnt_r == '0);
  assign do_push       = push && !wr_stat.full;
  assign do_pop        = pop && !rd_stat.empty;
  assign head_job      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- design/circ_front.sv -----
// ============================================================================
// circ_front
// Accepts requests, holds the circle state and runs the decision update.
// ============================================================================
module circ_front (
  input  logic                 clk,
  input  logic                 rst_n,
  circ_in_if.sink              in_if,
  input  circ_pkg::q_wr_stat_t wr_stat,
  output logic                 push,
  output circ_pkg::job_t       push_job
);
  import circ_pkg::*;

  logic signed [COORD_W-1:0]  cx_r, cx_nxt;
  logic signed [COORD_W-1:0]  cy_r, cy_nxt;
  logic        [RADIUS_W-1:0] rad_r, rad_nxt;
  logic        [RADIUS_W-1:0] ox_r, ox_nxt;
  logic        [RADIUS_W-1:0] oy_r, oy_nxt;
  logic signed [DEC_W-1:0]    dec_r, dec_nxt;
  logic                       fill_r, fill_nxt;
  logic                       active_r, active_nxt;

  logic                       acc;
  logic signed [EXT_W-1:0]    d_e, ox_e, oy_e, r_e;
  logic signed [EXT_W-1:0]    d_new, ox_new, oy_new;
  logic                       step_done;

  assign in_if.ready = !wr_stat.full;
  assign acc         = in_if.valid && in_if.ready;

  assign d_e  = EXT_W'(dec_r);
  assign ox_e = signed'(EXT_W'(ox_r));
  assign oy_e = signed'(EXT_W'(oy_r));
  assign r_e  = signed'(EXT_W'(rad_r));

  // Three-branch rule: step right, step down, or step diagonally.
  always_comb begin
    if (d_e >= (ox_e <<< 1)) begin
      d_new  = d_e - (ox_e <<< 1) - EXT_W'(1);
      ox_new = ox_e + EXT_W'(1);
      oy_new = oy_e;
    end else if (d_e < ((r_e - oy_e) <<< 1)) begin
      d_new  = d_e + (oy_e <<< 1) - EXT_W'(1);
      ox_new = ox_e;
      oy_new = oy_e - EXT_W'(1);
    end else begin
      d_new  = d_e + ((oy_e - ox_e - EXT_W'(1)) <<< 1);
      ox_new = ox_e + EXT_W'(1);
      oy_new = oy_e - EXT_W'(1);
    end
  end

  assign step_done = (oy_new < ox_new);

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rad_nxt    = rad_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    dec_nxt    = dec_r;
    fill_nxt   = fill_r;
    active_nxt = active_r;
    if (acc) begin
      if (in_if.command == CMD_START) begin
        cx_nxt     = in_if.center_x;
        cy_nxt     = in_if.center_y;
        rad_nxt    = in_if.radius;
        ox_nxt     = '0;
        oy_nxt     = in_if.radius;
        dec_nxt    = DEC_W'(signed'(EXT_W'(in_if.radius)) - EXT_W'(1));
        fill_nxt   = in_if.filled;
        active_nxt = 1'b1;
      end else if (active_r) begin
        ox_nxt     = ox_new[RADIUS_W-1:0];
        oy_nxt     = oy_new[RADIUS_W-1:0];
        dec_nxt    = d_new[DEC_W-1:0];
        active_nxt = !step_done;
      end
    end
  end

  // Only step requests produce work; the job snapshots the pre-update offsets.
  always_comb begin
    push          = acc && (in_if.command == CMD_STEP);
    push_job.live = active_r;
    push_job.fill = fill_r;
    push_job.done = step_done;
    push_job.cx   = cx_r;
    push_job.cy   = cy_r;
    push_job.ox   = ox_r;
    push_job.oy   = oy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      rad_r    <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      dec_r    <= '0;
      fill_r   <= 1'b0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      rad_r    <= rad_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      dec_r    <= dec_nxt;
      fill_r   <= fill_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ----- design/circ_back.sv -----
// ============================================================================
// circ_back
// Expands one step job into points or spans, one result per cycle if not stalled.
// ============================================================================
module circ_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  circ_pkg::job_t       head_job,
  input  circ_pkg::q_rd_stat_t rd_stat,
  output logic                 pop,
  circ_out_if.source           out_if
);
  import circ_pkg::*;

  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [OUT_W-1:0] xs_r, xe_r, y_r;
  logic                    vres_r, last_r, done_r;

  logic                    load, emit, is_last;
  logic [IDX_W-1:0]        last_idx;
  logic                    swap, xneg, yneg;
  logic [RADIUS_W-1:0]     a, b;
  logic signed [OUT_W-1:0] cx_e, cy_e, a_e, b_e;
  logic signed [OUT_W-1:0] xs_c, xe_c, y_c;

  assign load = !ov_r || out_if.ready;
  assign emit = load && !rd_stat.empty;

  always_comb begin
    if (!head_job.live) begin
      last_idx = '0;
    end else if (head_job.fill) begin
      last_idx = IDX_W'(3);
    end else begin
      last_idx = IDX_W'(7);
    end
  end

  assign is_last = (idx_r == last_idx);
  assign pop     = emit && is_last;

  // Octant selection: outline points walk swap/x-sign/y-sign through the
  // index bits; spans use the offset pair symmetric about the center column.
  always_comb begin
    if (head_job.fill) begin
      swap = !(idx_r[0] ^ idx_r[1]);
      xneg = 1'b0;
      yneg = idx_r[1];
    end else begin
      swap = idx_r[0];
      xneg = idx_r[1];
      yneg = idx_r[2];
    end
    a = swap ? head_job.oy : head_job.ox;
    b = swap ? head_job.ox : head_job.oy;
  end

  assign cx_e = OUT_W'(head_job.cx);
  assign cy_e = OUT_W'(head_job.cy);
  assign a_e  = signed'(OUT_W'(a));
  assign b_e  = signed'(OUT_W'(b));

  always_comb begin
    if (head_job.fill) begin
      xs_c = cx_e - a_e;
      xe_c = cx_e + a_e;
    end else begin
      xs_c = xneg ? (cx_e - a_e) : (cx_e + a_e);
      xe_c = xs_c;
    end
    y_c = yneg ? (cy_e - b_e) : (cy_e + b_e);
  end

  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (load) begin
      ov_nxt = !rd_stat.empty;
    end
    if (emit) begin
      idx_nxt = is_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (head_job.live) begin
        xs_r   <= xs_c;
        xe_r   <= xe_c;
        y_r    <= y_c;
        vres_r <= 1'b1;
        last_r <= is_last;
        done_r <= is_last && head_job.done;
      end else begin
        xs_r   <= '0;
        xe_r   <= '0;
        y_r    <= '0;
        vres_r <= 1'b0;
        last_r <= 1'b1;
        done_r <= 1'b1;
      end
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.x_start   = xs_r;
  assign out_if.x_end     = xe_r;
  assign out_if.y_coord   = y_r;
  assign out_if.valid_res = vres_r;
  assign out_if.last      = last_r;
  assign out_if.done_res  = done_r;

endmodule

// ----- design/circle_rasterizer.sv -----
// ============================================================================
// circle_rasterizer
// Three-branch circle rasterizer producing octant points or filled spans.
// ============================================================================
// Usage: requests arrive on in_if. A start request (command = 0) loads the
// center, the radius and the fill flag and produces no results. Each step
// request (command = 1) produces the results of one octant step on out_if:
// eight single-pixel points in outline mode, four horizontal spans in fill
// mode, or one result with valid_res = 0 when no circle is active. The last
// result of a step carries last = 1, and done_res = 1 when the circle ends.
//
// An accepted step request is written into the queue; its first result is
// then loaded from the queue head into the result register and offered on
// out_if. Throughput is set by the result register, which drains one result
// per cycle while out_if.ready is high. The front end updates the circle
// state in the cycle of acceptance and parks the step in a two-entry queue,
// so start and step requests are taken every cycle as long as that queue
// has room.
//
// Reset (synchronous, active low) clears the circle state to idle, empties
// the queue and drops any result on offer. When out_if.ready is held low the
// current result holds; the queue fills and then in_if.ready falls.
// ============================================================================
module circle_rasterizer (
  input  logic       clk,
  input  logic       rst_n,
  circ_in_if.sink    in_if,
  circ_out_if.source out_if
);
  import circ_pkg::*;

  job_t       push_job, head_job;
  logic       push, pop;
  q_wr_stat_t wr_stat;
  q_rd_stat_t rd_stat;

  // Front end: request intake and decision-variable update.
  circ_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .wr_stat  (wr_stat),
    .push     (push),
    .push_job (push_job)
  );

  // Decoupling queue of pending steps.
  circ_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .wr_stat  (wr_stat),
    .pop      (pop),
    .head_job (head_job),
    .rd_stat  (rd_stat)
  );

  // Back end: coordinate generation into the registered result stage.
  circ_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .rd_stat  (rd_stat),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule

// ----- design/circ_checker.sv -----
// ============================================================================
// circ_checker
// Port-level checks on the circle rasterizer result channel.
// ============================================================================
module circ_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [circ_pkg::OUT_W-1:0] out_x_start,
  input logic [circ_pkg::OUT_W-1:0] out_x_end,
  input logic [circ_pkg::OUT_W-1:0] out_y_coord,
  input logic out_valid_res,
  input logic out_last,
  input logic out_done_res
);
  import circ_pkg::*;

  // A result on offer is not withdrawn before it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Completion is only flagged on the final result of a step.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_last)
    else $error("done without last");

  // An idle step yields one empty, final, done result at the origin.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_last && out_done_res &&
      out_x_start == '0 && out_x_end == '0 && out_y_coord == '0)
    else $error("malformed idle result");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind circle_rasterizer circ_checker u_circ_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_x_start   (out_if.x_start),
  .out_x_end     (out_if.x_end),
  .out_y_coord   (out_if.y_coord),
  .out_valid_res (out_if.valid_res),
  .out_last      (out_if.last),
  .out_done_res  (out_if.done_res)
);
